### hw/rtl/cdst_pkg.sv
package cdst_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned WdayW  = 3;
  localparam int unsigned KindW  = 4;
  localparam int unsigned Mod25W = 5;

  localparam logic [YearW-1:0]  YearMin      = 14'd1973;
  localparam logic [YearW-1:0]  YearMax      = 14'd9999;
  localparam logic [Mod25W-1:0] YearMinMod25 = 5'd23;
  localparam logic [Mod25W-1:0] Mod25Last    = 5'd24;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthMar = 4'd3;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // reciprocal constants for division by 25 (exact below 2^14) and by 7 (exact below 2^15)
  localparam logic [12:0] Div25Mul = 13'd5243;
  localparam logic [15:0] Div7Mul  = 16'd37450;

  typedef enum logic [KindW-1:0] {
    K_NEXT_DAY   = 4'd0,
    K_PREV_DAY   = 4'd1,
    K_NEXT_MONTH = 4'd2,
    K_PREV_MONTH = 4'd3,
    K_NEXT_YEAR  = 4'd4,
    K_PREV_YEAR  = 4'd5,
    K_SET_DATE   = 4'd6,
    K_SET_YEAR   = 4'd7,
    K_SET_MONTH  = 4'd8,
    K_SET_DAY    = 4'd9,
    K_READ       = 4'd10
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  typedef struct packed {
    logic [KindW-1:0]  kind;
    logic [YearW-1:0]  new_year;
    logic [MonthW-1:0] new_month;
    logic [DayW-1:0]   new_day;
  } in_item_t;

  typedef struct packed {
    logic [YearW-1:0]  cur_year;
    logic [MonthW-1:0] cur_month;
    logic [DayW-1:0]   cur_day;
    logic [WdayW-1:0]  weekday;
    status_e           status;
  } out_item_t;

  // classified command between front and back
  typedef struct packed {
    kind_e             kind;
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [Mod25W-1:0] year_mod25;
    logic              year_ok;
    logic              month_ok;
    logic              date_ok;
  } cmd_t;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    status_e           status;
  } res_t;

  function automatic logic is_leap(logic [YearW-1:0] y, logic [Mod25W-1:0] y_mod25);
    return (y[1:0] == 2'b00) && ((y_mod25 != '0) || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DayW-1:0] month_len(logic leap, logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  function automatic logic [9:0] div25(logic [YearW-1:0] v);
    logic [26:0] prod;
    prod = 27'(v) * 27'(Div25Mul);
    return prod[26:17];
  endfunction

  function automatic logic [WdayW-1:0] mod7(logic [14:0] s);
    logic [30:0] prod;
    logic [12:0] q;
    logic [15:0] q7;
    logic [15:0] rem;
    prod = 31'(s) * 31'(Div7Mul);
    q    = prod[30:18];
    q7   = {q, 3'b000} - {3'b000, q};
    rem  = {1'b0, s} - q7;
    return rem[2:0];
  endfunction

  function automatic logic [2:0] sak_offset(logic [MonthW-1:0] m);
    logic [2:0] off;
    case (m)
      4'd1:    off = 3'd0;
      4'd2:    off = 3'd3;
      4'd3:    off = 3'd2;
      4'd4:    off = 3'd5;
      4'd5:    off = 3'd0;
      4'd6:    off = 3'd3;
      4'd7:    off = 3'd5;
      4'd8:    off = 3'd1;
      4'd9:    off = 3'd4;
      4'd10:   off = 3'd6;
      4'd11:   off = 3'd2;
      4'd12:   off = 3'd4;
      default: off = 3'd0;
    endcase
    return off;
  endfunction

endpackage

### hw/rtl/calendar_date_stepper.sv
// an accepted input transaction passes through the command queue and the back unit's result register
// throughput: one transaction per cycle while the output is not stalled, set by the date update loop in the back unit
// the weekday is worked out in a three-register pipeline behind the back unit's result register
// reset: date is 1 january 1973, command queue and result pipeline are empty
module calendar_date_stepper #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cdst_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdst_pkg::out_item_t out_item_o
);
  import cdst_pkg::*;

  // classified command on its way into the queue
  cmd_t cmd_in;
  // head of the queue towards the back unit
  cmd_t cmd_head;
  logic cmd_valid, cmd_ready;
  // updated date and status towards the weekday pipeline
  res_t res;
  logic res_valid, res_ready;

  // front: decodes the command kind, checks set operands against their ranges and works out
  // the year residue mod 25 that leap-year tests need later on
  cdst_front u_front (
    .item_i (in_item_i),
    .cmd_o  (cmd_in)
  );

  // short queue so that the front keeps taking transactions while the back stalls
  cdst_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wvalid_i (in_valid_i),
    .wready_o (in_ready_o),
    .wdata_i  (cmd_in),
    .rvalid_o (cmd_valid),
    .rready_i (cmd_ready),
    .rdata_o  (cmd_head)
  );

  // back: holds the date and applies one command per cycle while its result register can move on
  cdst_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd_head),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // weekday by the offset-table method, ending in the output register
  cdst_wday u_wday (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_ready_o (res_ready),
    .res_i       (res),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_item_o)
  );

endmodule

### hw/rtl/cdst_front.sv
module cdst_front (
  input  cdst_pkg::in_item_t item_i,
  output cdst_pkg::cmd_t     cmd_o
);
  import cdst_pkg::*;

  logic [9:0]       quot25;
  logic [YearW-1:0] quot25_x25;
  logic [YearW-1:0] rem25;
  logic             leap_new;
  logic             day_ok;

  // year mod 25 by reciprocal multiply and back-subtract
  assign quot25     = div25(item_i.new_year);
  assign quot25_x25 = {quot25, 4'b0000} + {1'b0, quot25, 3'b000} + {4'b0000, quot25};
  assign rem25      = item_i.new_year - quot25_x25;
  assign leap_new   = is_leap(item_i.new_year, rem25[Mod25W-1:0]);

  assign day_ok = (item_i.new_day != '0) &&
                  (item_i.new_day <= month_len(leap_new, item_i.new_month));

  always_comb begin
    cmd_o.year       = item_i.new_year;
    cmd_o.month      = item_i.new_month;
    cmd_o.day        = item_i.new_day;
    cmd_o.year_mod25 = rem25[Mod25W-1:0];
    cmd_o.year_ok    = (item_i.new_year >= YearMin) && (item_i.new_year <= YearMax);
    cmd_o.month_ok   = (item_i.new_month >= MonthJan) && (item_i.new_month <= MonthDec);
    cmd_o.date_ok    = cmd_o.year_ok && cmd_o.month_ok && day_ok;
    case (item_i.kind)
      K_NEXT_DAY, K_PREV_DAY, K_NEXT_MONTH, K_PREV_MONTH, K_NEXT_YEAR,
      K_PREV_YEAR, K_SET_DATE, K_SET_YEAR, K_SET_MONTH, K_SET_DAY: begin
        cmd_o.kind = kind_e'(item_i.kind);
      end
      default: begin
        cmd_o.kind = K_READ;
      end
    endcase
  end

endmodule

### hw/rtl/cdst_queue.sv
module cdst_queue #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wvalid_i,
  output logic            wready_o,
  input  cdst_pkg::cmd_t  wdata_i,
  output logic            rvalid_o,
  input  logic            rready_i,
  output cdst_pkg::cmd_t  rdata_o
);
  import cdst_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign wready_o = (cnt_q != CntW'(Depth));
  assign rvalid_o = (cnt_q != '0);
  assign push     = wvalid_i && wready_o;
  assign pop      = rvalid_o && rready_i;
  assign rdata_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(wptr_q + 1'b1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : PtrW'(rptr_q + 1'b1);
    end
    if (push && !pop) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end else if (pop && !push) begin
      cnt_d = CntW'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntW'(Depth))
    else $error("queue fill count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == CntW'($past(cnt_q) + 1'b1))
    else $error("queue count missed a push");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wptr_q == rptr_q))
    else $error("empty queue with pointers apart");

endmodule

### hw/rtl/cdst_back.sv
module cdst_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  cdst_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output cdst_pkg::res_t  res_o
);
  import cdst_pkg::*;

  logic [YearW-1:0]  year_q, year_d;
  logic [MonthW-1:0] month_q, month_d;
  logic [DayW-1:0]   day_q, day_d;
  logic [Mod25W-1:0] ym25_q, ym25_d;
  status_e           st_d;
  res_t              res_q;
  logic              res_valid_q;
  logic              fire;

  logic              leap_cur;
  logic [DayW-1:0]   len_cur, len_next, len_prev;
  logic [MonthW-1:0] month_inc, month_dec;
  logic [Mod25W-1:0] ym25_inc, ym25_dec;

  assign cmd_ready_o = !res_valid_q || res_ready_i;
  assign fire        = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign leap_cur  = is_leap(year_q, ym25_q);
  assign month_inc = MonthW'(month_q + 1'b1);
  assign month_dec = MonthW'(month_q - 1'b1);
  assign len_cur   = month_len(leap_cur, month_q);
  assign len_next  = month_len(leap_cur, month_inc);
  assign len_prev  = month_len(leap_cur, month_dec);
  assign ym25_inc  = (ym25_q == Mod25Last) ? '0 : Mod25W'(ym25_q + 1'b1);
  assign ym25_dec  = (ym25_q == '0) ? Mod25Last : Mod25W'(ym25_q - 1'b1);

  always_comb begin
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    ym25_d  = ym25_q;
    st_d    = ST_OK;
    case (cmd_i.kind)
      K_NEXT_DAY: begin
        if (day_q >= len_cur) begin
          if (month_q != MonthDec) begin
            month_d = month_inc;
            day_d   = 5'd1;
          end else if (year_q < YearMax) begin
            year_d  = YearW'(year_q + 1'b1);
            ym25_d  = ym25_inc;
            month_d = MonthJan;
            day_d   = 5'd1;
          end else begin
            st_d = ST_RANGE;
          end
        end else begin
          day_d = DayW'(day_q + 1'b1);
        end
      end
      K_PREV_DAY: begin
        if (day_q > 5'd1) begin
          day_d = DayW'(day_q - 1'b1);
        end else if (month_q != MonthJan) begin
          month_d = month_dec;
          day_d   = len_prev;
        end else if (year_q > YearMin) begin
          year_d  = YearW'(year_q - 1'b1);
          ym25_d  = ym25_dec;
          month_d = MonthDec;
          day_d   = 5'd31;
        end else begin
          st_d = ST_RANGE;
        end
      end
      K_NEXT_MONTH: begin
        // january and december are 31 days long, so only a same-year step clamps
        if (month_q != MonthDec) begin
          month_d = month_inc;
          day_d   = (day_q > len_next) ? len_next : day_q;
        end else if (year_q < YearMax) begin
          month_d = MonthJan;
          year_d  = YearW'(year_q + 1'b1);
          ym25_d  = ym25_inc;
        end else begin
          st_d = ST_RANGE;
        end
      end
      K_PREV_MONTH: begin
        if (month_q != MonthJan) begin
          month_d = month_dec;
          day_d   = (day_q > len_prev) ? len_prev : day_q;
        end else if (year_q > YearMin) begin
          month_d = MonthDec;
          year_d  = YearW'(year_q - 1'b1);
          ym25_d  = ym25_dec;
        end else begin
          st_d = ST_RANGE;
        end
      end
      K_NEXT_YEAR, K_PREV_YEAR: begin
        if (((cmd_i.kind == K_NEXT_YEAR) && (year_q < YearMax)) ||
            ((cmd_i.kind == K_PREV_YEAR) && (year_q > YearMin))) begin
          if (leap_cur && (month_q == MonthFeb) && (day_q == 5'd29)) begin
            day_d = 5'd28;
          end
          if (cmd_i.kind == K_NEXT_YEAR) begin
            year_d = YearW'(year_q + 1'b1);
            ym25_d = ym25_inc;
          end else begin
            year_d = YearW'(year_q - 1'b1);
            ym25_d = ym25_dec;
          end
        end else begin
          st_d = ST_RANGE;
        end
      end
      K_SET_DATE: begin
        if (cmd_i.date_ok) begin
          year_d  = cmd_i.year;
          ym25_d  = cmd_i.year_mod25;
          month_d = cmd_i.month;
          day_d   = cmd_i.day;
        end else begin
          st_d = ST_INVALID;
        end
      end
      K_SET_YEAR: begin
        if (cmd_i.year_ok) begin
          year_d = cmd_i.year;
          ym25_d = cmd_i.year_mod25;
        end else begin
          st_d = ST_INVALID;
        end
      end
      K_SET_MONTH: begin
        if (cmd_i.month_ok) begin
          month_d = cmd_i.month;
        end else begin
          st_d = ST_INVALID;
        end
      end
      K_SET_DAY: begin
        if ((cmd_i.day != '0) && (cmd_i.day <= len_cur)) begin
          day_d = cmd_i.day;
        end else begin
          st_d = ST_INVALID;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_q      <= YearMin;
      month_q     <= MonthJan;
      day_q       <= 5'd1;
      ym25_q      <= YearMinMod25;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        year_q  <= year_d;
        month_q <= month_d;
        day_q   <= day_d;
        ym25_q  <= ym25_d;
      end
      if (cmd_ready_o) begin
        res_valid_q <= cmd_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q.year   <= year_d;
      res_q.month  <= month_d;
      res_q.day    <= day_d;
      res_q.status <= st_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (year_q >= YearMin) && (year_q <= YearMax) && (month_q >= MonthJan) &&
    (month_q <= MonthDec) && (day_q != '0))
    else $error("stored date left its range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (st_d != ST_OK) |=>
    (year_q == $past(year_q)) && (month_q == $past(month_q)) && (day_q == $past(day_q)))
    else $error("rejected command changed the date");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ym25_q <= Mod25Last) && ((year_q != YearMin) || (ym25_q == YearMinMod25)))
    else $error("year residue out of step with year");

endmodule

### hw/rtl/cdst_wday.sv
module cdst_wday (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                res_valid_i,
  output logic                res_ready_o,
  input  cdst_pkg::res_t      res_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cdst_pkg::out_item_t out_o
);
  import cdst_pkg::*;

  typedef struct packed {
    res_t             res;
    logic [YearW-1:0] yy;
    logic [11:0]      qtr;
    logic [7:0]       cent;
  } stage_a_t;

  typedef struct packed {
    res_t        res;
    logic [14:0] sum;
  } stage_b_t;

  stage_a_t         a_d, a_q;
  stage_b_t         b_d, b_q;
  out_item_t        o_d, o_q;
  logic             a_valid_q, b_valid_q, o_valid_q;
  logic             a_ready, b_ready, o_ready;
  logic [YearW-1:0] yy;
  logic [9:0]       cent_full;

  assign o_ready     = !o_valid_q || out_ready_i;
  assign b_ready     = !b_valid_q || o_ready;
  assign a_ready     = !a_valid_q || b_ready;
  assign res_ready_o = a_ready;
  assign out_valid_o = o_valid_q;
  assign out_o       = o_q;

  // january and february count with the previous year
  assign yy        = YearW'(res_i.year - {{(YearW-1){1'b0}}, (res_i.month < MonthMar)});
  assign cent_full = div25({2'b00, yy[YearW-1:2]});

  always_comb begin
    a_d.res  = res_i;
    a_d.yy   = yy;
    a_d.qtr  = yy[YearW-1:2];
    a_d.cent = cent_full[7:0];

    b_d.res = a_q.res;
    b_d.sum = 15'(a_q.yy) + 15'(a_q.qtr) - 15'(a_q.cent) + 15'(a_q.cent[7:2]) +
              15'(sak_offset(a_q.res.month)) + 15'(a_q.res.day);

    o_d.cur_year  = b_q.res.year;
    o_d.cur_month = b_q.res.month;
    o_d.cur_day   = b_q.res.day;
    o_d.weekday   = mod7(b_q.sum);
    o_d.status    = b_q.res.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_q <= res_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= b_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_ready && res_valid_i) begin
      a_q <= a_d;
    end
    if (b_ready && a_valid_q) begin
      b_q <= b_d;
    end
    if (o_ready && b_valid_q) begin
      o_q <= o_d;
    end
  end

endmodule

### verif/tb_calendar_date_stepper.sv
module tb_calendar_date_stepper;
  import cdst_pkg::*;

  // random traffic size and the quiet-cycle limit of the watchdog
  localparam int unsigned RandomItems   = 1250;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned ReportedFaults = 10;

  // a kind code outside the defined commands, which the block treats as a read
  localparam logic [KindW-1:0] KindSpare = 4'hF;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  // shadow copy of the date register, advanced once per accepted command
  int unsigned cal_year  = YearMin;
  int unsigned cal_month = 1;
  int unsigned cal_day   = 1;

  // dates still owed by the block, oldest first
  out_item_t   pending_dates[$];
  int unsigned fault_cnt    = 0;
  int unsigned quiet_cycles = 0;
  // when set, neither side inserts gaps or stalls
  logic        no_gaps      = 1'b0;

  calendar_date_stepper u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic for the predictor
  // ---------------------------------------------------------------------------

  function automatic logic leap_year(int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned days_in_month(int unsigned y, int unsigned m);
    if (m == 2) begin
      return leap_year(y) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // month term of the day-of-week sum
  function automatic int unsigned month_shift(int unsigned m);
    case (m)
      2, 6:    return 3;
      3, 11:   return 2;
      4, 7:    return 5;
      8:       return 1;
      9, 12:   return 4;
      10:      return 6;
      default: return 0;
    endcase
  endfunction

  // day of week with sunday as zero; january and february count in the year before
  function automatic logic [WdayW-1:0] day_of_week(int unsigned y, int unsigned m,
                                                   int unsigned d);
    int unsigned yy;
    yy = (m < 3) ? y - 1 : y;
    return WdayW'((yy + yy / 4 - yy / 100 + yy / 400 + month_shift(m) + d) % 7);
  endfunction

  // clamp the stored day to the length of the stored month
  function automatic void trim_day();
    if (cal_day > days_in_month(cal_year, cal_month)) begin
      cal_day = days_in_month(cal_year, cal_month);
    end
  endfunction

  // apply one command to the shadow date and return the result it must produce
  function automatic out_item_t date_after_cmd(in_item_t c);
    int unsigned ny;
    int unsigned nm;
    int unsigned nd;
    status_e     st;
    out_item_t   r;
    ny = c.new_year;
    nm = c.new_month;
    nd = c.new_day;
    st = ST_OK;
    case (c.kind)
      K_NEXT_DAY: begin
        // a day at or beyond the month's length rolls to the first of the next month
        if (cal_day >= days_in_month(cal_year, cal_month)) begin
          if (cal_month != 12) begin
            cal_month = cal_month + 1;
            cal_day   = 1;
          end else if (cal_year < YearMax) begin
            cal_year  = cal_year + 1;
            cal_month = 1;
            cal_day   = 1;
          end else begin
            st = ST_RANGE;
          end
        end else begin
          cal_day = cal_day + 1;
        end
      end
      K_PREV_DAY: begin
        if (cal_day > 1) begin
          cal_day = cal_day - 1;
        end else if (cal_month != 1) begin
          cal_month = cal_month - 1;
          cal_day   = days_in_month(cal_year, cal_month);
        end else if (cal_year > YearMin) begin
          cal_year  = cal_year - 1;
          cal_month = 12;
          cal_day   = 31;
        end else begin
          st = ST_RANGE;
        end
      end
      K_NEXT_MONTH: begin
        if (cal_month != 12) begin
          cal_month = cal_month + 1;
        end else if (cal_year < YearMax) begin
          cal_month = 1;
          cal_year  = cal_year + 1;
        end else begin
          st = ST_RANGE;
        end
        trim_day();
      end
      K_PREV_MONTH: begin
        if (cal_month != 1) begin
          cal_month = cal_month - 1;
        end else if (cal_year > YearMin) begin
          cal_month = 12;
          cal_year  = cal_year - 1;
        end else begin
          st = ST_RANGE;
        end
        trim_day();
      end
      K_NEXT_YEAR: begin
        // 29 february of a leap year becomes the 28th before the year moves
        if (cal_year < YearMax) begin
          if (leap_year(cal_year) && cal_month == 2 && cal_day == 29) begin
            cal_day = 28;
          end
          cal_year = cal_year + 1;
        end else begin
          st = ST_RANGE;
        end
      end
      K_PREV_YEAR: begin
        if (cal_year > YearMin) begin
          if (leap_year(cal_year) && cal_month == 2 && cal_day == 29) begin
            cal_day = 28;
          end
          cal_year = cal_year - 1;
        end else begin
          st = ST_RANGE;
        end
      end
      K_SET_DATE: begin
        if (ny >= YearMin && ny <= YearMax && nm >= 1 && nm <= 12 &&
            nd >= 1 && nd <= days_in_month(ny, nm)) begin
          cal_year  = ny;
          cal_month = nm;
          cal_day   = nd;
        end else begin
          st = ST_INVALID;
        end
      end
      K_SET_YEAR: begin
        // the day is kept, so the date may run past the end of its month
        if (ny >= YearMin && ny <= YearMax) begin
          cal_year = ny;
        end else begin
          st = ST_INVALID;
        end
      end
      K_SET_MONTH: begin
        if (nm >= 1 && nm <= 12) begin
          cal_month = nm;
        end else begin
          st = ST_INVALID;
        end
      end
      K_SET_DAY: begin
        if (nd >= 1 && nd <= days_in_month(cal_year, cal_month)) begin
          cal_day = nd;
        end else begin
          st = ST_INVALID;
        end
      end
      default: begin
        // read and the spare codes leave the date alone
      end
    endcase
    r.cur_year  = YearW'(cal_year);
    r.cur_month = MonthW'(cal_month);
    r.cur_day   = DayW'(cal_day);
    r.weekday   = day_of_week(cal_year, cal_month, cal_day);
    r.status    = st;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // scoreboard and watchdog
  // ---------------------------------------------------------------------------

  function automatic void flag_fault(string field, int unsigned want, int unsigned got);
    fault_cnt++;
    if (fault_cnt <= ReportedFaults) begin
      $display("mismatch in %s: expected %0d, got %0d", field, want, got);
    end
  endfunction

  // both handshakes are sampled here; a command is predicted before any
  // result of the same edge is popped, so the order is fixed
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        pending_dates.push_back(date_after_cmd(in_item_i));
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_dates.size() == 0) begin
          fault_cnt++;
          if (fault_cnt <= ReportedFaults) begin
            $display("result transaction with no command outstanding");
          end
        end else begin
          out_item_t want;
          want = pending_dates.pop_front();
          if (out_item_o.cur_year !== want.cur_year) begin
            flag_fault("year", want.cur_year, out_item_o.cur_year);
          end
          if (out_item_o.cur_month !== want.cur_month) begin
            flag_fault("month", want.cur_month, out_item_o.cur_month);
          end
          if (out_item_o.cur_day !== want.cur_day) begin
            flag_fault("day", want.cur_day, out_item_o.cur_day);
          end
          if (out_item_o.weekday !== want.weekday) begin
            flag_fault("weekday", want.weekday, out_item_o.weekday);
          end
          if (out_item_o.status !== want.status) begin
            flag_fault("status", want.status, out_item_o.status);
          end
        end
      end
      // any transaction on either side keeps the watchdog quiet
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side: stalls about 17 percent of the time unless gaps are off
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ready_i <= no_gaps || ($urandom_range(99) >= 17);
    end
  end

  // ---------------------------------------------------------------------------
  // command side
  // ---------------------------------------------------------------------------

  // present one command, with random gaps before it, and hold it until taken
  task automatic send_cmd(in_item_t c);
    @(negedge clk_i);
    while (!no_gaps && $urandom_range(99) < 17) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic issue(logic [KindW-1:0] k, int unsigned y, int unsigned m, int unsigned d);
    in_item_t c;
    c.kind      = k;
    c.new_year  = YearW'(y);
    c.new_month = MonthW'(m);
    c.new_day   = DayW'(d);
    send_cmd(c);
  endtask

  // drop valid so the last command is not taken twice
  task automatic release_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // hold off the sender until every owed result has come back
  task automatic wait_for_results();
    release_input();
    while (pending_dates.size() != 0) @(negedge clk_i);
  endtask

  // year picker that leans towards the range ends and the century leap cases
  function automatic int unsigned pick_year();
    if ($urandom_range(99) < 30) begin
      case ($urandom_range(5))
        0:       return YearMin;
        1:       return YearMin + 1;
        2:       return YearMax;
        3:       return YearMax - 1;
        4:       return 2000;
        default: return 2100;
      endcase
    end
    return $urandom_range(YearMax, YearMin);
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // the date after reset is 1 january 1973
  task automatic test_power_on_date();
    issue(K_READ, 0, 0, 0);
  endtask

  // every backward step from the first date is refused
  task automatic test_lower_bound();
    issue(K_PREV_DAY, 0, 0, 0);
    issue(K_PREV_MONTH, 0, 0, 0);
    issue(K_PREV_YEAR, 0, 0, 0);
  endtask

  // 29 february of a century leap year, forward and back across it
  task automatic test_leap_february();
    issue(K_SET_DATE, 2000, 2, 28);
    issue(K_NEXT_DAY, 0, 0, 0);
    issue(K_NEXT_DAY, 0, 0, 0);
    issue(K_PREV_DAY, 0, 0, 0);
  endtask

  // every forward step from the last date is refused
  task automatic test_upper_bound();
    issue(K_SET_DATE, YearMax, 12, 31);
    issue(K_NEXT_DAY, 0, 0, 0);
    issue(K_NEXT_MONTH, 0, 0, 0);
    issue(K_NEXT_YEAR, 0, 0, 0);
  endtask

  // month steps clamp to the month length, year steps pull 29 february back
  task automatic test_month_clamp();
    issue(K_SET_DATE, 2024, 1, 31);
    issue(K_NEXT_MONTH, 0, 0, 0);
    issue(K_NEXT_YEAR, 0, 0, 0);
    issue(K_PREV_MONTH, 0, 0, 0);
  endtask

  // sets that fail their checks leave the date as it was
  task automatic test_rejected_sets();
    issue(K_SET_DATE, 16383, 15, 31);
    issue(K_SET_DATE, 0, 0, 0);
    issue(K_SET_DATE, 2100, 2, 29);
    issue(K_SET_YEAR, YearMin - 1, 0, 0);
    issue(K_SET_MONTH, 0, 13, 0);
    issue(K_SET_DAY, 0, 0, 0);
  endtask

  // a month set may leave a day past the month's end, which next day rolls over
  task automatic test_overlong_day();
    issue(K_SET_DAY, 0, 0, 31);
    issue(K_SET_MONTH, 0, 2, 0);
    issue(K_NEXT_DAY, 0, 0, 0);
  endtask

  // a spare kind code with every operand bit set acts as a read
  task automatic test_spare_kind();
    issue(KindSpare, 16383, 15, 31);
  endtask

  // mostly steps and well-formed sets with random content, the rest noise
  task automatic test_random_traffic();
    in_item_t    c;
    logic [31:0] noise;
    int unsigned pick;
    int unsigned y;
    int unsigned m;
    for (int i = 0; i < RandomItems; i++) begin
      // a stretch with no gaps or stalls on either side
      no_gaps = (i >= 300 && i < 550);
      // let the pipeline run dry once in mid-traffic
      if (i == 800) begin
        wait_for_results();
      end
      noise       = $urandom;
      c.new_year  = noise[13:0];
      c.new_month = noise[17:14];
      c.new_day   = noise[22:18];
      c.kind      = noise[26:23];
      pick        = $urandom_range(99);
      if (pick < 50) begin
        c.kind = KindW'($urandom_range(K_PREV_YEAR, K_NEXT_DAY));
      end else if (pick < 64) begin
        y = pick_year();
        m = $urandom_range(12, 1);
        if ($urandom_range(3) == 0) begin
          m = ($urandom_range(1) == 0) ? 1 : 12;
        end
        c.kind      = K_SET_DATE;
        c.new_year  = YearW'(y);
        c.new_month = MonthW'(m);
        c.new_day   = DayW'($urandom_range(days_in_month(y, m), 1));
      end else if (pick < 72) begin
        c.kind = K_SET_YEAR;
        if ($urandom_range(3) != 0) begin
          c.new_year = YearW'(pick_year());
        end
      end else if (pick < 79) begin
        c.kind = K_SET_MONTH;
      end else if (pick < 87) begin
        c.kind = K_SET_DAY;
      end else if (pick < 93) begin
        // set date with raw operands, mostly refused
        c.kind = K_SET_DATE;
      end else begin
        c.kind = KindW'($urandom_range(KindSpare, K_READ));
      end
      send_cmd(c);
    end
    no_gaps = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_power_on_date();
    test_lower_bound();
    test_leap_february();
    test_upper_bound();
    test_month_clamp();
    test_rejected_sets();
    test_overlong_day();
    test_spare_kind();
    test_random_traffic();

    // everything owed must arrive, then the drain wait catches any stray results
    wait_for_results();
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    if (fault_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/cdst_pkg.sv
hw/rtl/cdst_front.sv
hw/rtl/cdst_queue.sv
hw/rtl/cdst_back.sv
hw/rtl/cdst_wday.sv
hw/rtl/calendar_date_stepper.sv
verif/tb_calendar_date_stepper.sv
